/* hdl/rv32dec_pkg.sv */
// ----------------------------------------------------------------------------
// rv32dec_pkg
// Types, codes and lookup functions shared by the instruction decoder.
// ----------------------------------------------------------------------------
package rv32dec_pkg;

  localparam int unsigned AddrWidth = 63;

  typedef struct packed {
    logic [31:0]          instr_word;
    logic [AddrWidth-1:0] fetch_address;
  } req_t;

  typedef struct packed {
    logic [AddrWidth-1:0] pass_address;
    logic [2:0]           instr_length;
    logic                 is_compressed;
    logic                 is_jump;
    logic [2:0]           format_kind;
    logic [1:0]           operand_count;
    logic [4:0]           first_reg;
    logic [4:0]           second_reg;
    logic signed [31:0]   immediate;
    logic [4:0]           instr_id;
  } res_t;

  localparam logic [4:0] OpcLoad   = 5'h00;
  localparam logic [4:0] OpcOpImm  = 5'h04;
  localparam logic [4:0] OpcAuipc  = 5'h05;
  localparam logic [4:0] OpcStore  = 5'h08;
  localparam logic [4:0] OpcLui    = 5'h0d;
  localparam logic [4:0] OpcBranch = 5'h18;
  localparam logic [4:0] OpcJalr   = 5'h19;
  localparam logic [4:0] OpcJal    = 5'h1b;

  localparam logic [2:0] FmtNone = 3'd0;
  localparam logic [2:0] FmtI    = 3'd1;
  localparam logic [2:0] FmtS    = 3'd2;
  localparam logic [2:0] FmtB    = 3'd3;
  localparam logic [2:0] FmtU    = 3'd4;
  localparam logic [2:0] FmtJ    = 3'd5;

  localparam logic [4:0] IdUnknown = 5'd0;
  localparam logic [4:0] IdLui     = 5'd1;
  localparam logic [4:0] IdAuipc   = 5'd2;
  localparam logic [4:0] IdJal     = 5'd3;
  localparam logic [4:0] IdJalr    = 5'd4;
  localparam logic [4:0] IdBeq     = 5'd5;
  localparam logic [4:0] IdBne     = 5'd6;
  localparam logic [4:0] IdBlt     = 5'd7;
  localparam logic [4:0] IdBge     = 5'd8;
  localparam logic [4:0] IdBltu    = 5'd9;
  localparam logic [4:0] IdBgeu    = 5'd10;
  localparam logic [4:0] IdLb      = 5'd11;
  localparam logic [4:0] IdLh      = 5'd12;
  localparam logic [4:0] IdLw      = 5'd13;
  localparam logic [4:0] IdLbu     = 5'd14;
  localparam logic [4:0] IdLhu     = 5'd15;
  localparam logic [4:0] IdSb      = 5'd16;
  localparam logic [4:0] IdSh      = 5'd17;
  localparam logic [4:0] IdSw      = 5'd18;
  localparam logic [4:0] IdAddi    = 5'd19;
  localparam logic [4:0] IdSlti    = 5'd20;
  localparam logic [4:0] IdSltiu   = 5'd21;
  localparam logic [4:0] IdXori    = 5'd22;
  localparam logic [4:0] IdOri     = 5'd23;
  localparam logic [4:0] IdAndi    = 5'd24;

  function automatic logic [4:0] branch_id(input logic [2:0] f3);
    logic [4:0] id;
    case (f3)
      3'd0: id = IdBeq;
      3'd1: id = IdBne;
      3'd4: id = IdBlt;
      3'd5: id = IdBge;
      3'd6: id = IdBltu;
      3'd7: id = IdBgeu;
      default: id = IdUnknown;
    endcase
    return id;
  endfunction

  function automatic logic [4:0] load_id(input logic [2:0] f3);
    logic [4:0] id;
    case (f3)
      3'd0: id = IdLb;
      3'd1: id = IdLh;
      3'd2: id = IdLw;
      3'd4: id = IdLbu;
      3'd5: id = IdLhu;
      default: id = IdUnknown;
    endcase
    return id;
  endfunction

  function automatic logic [4:0] store_id(input logic [2:0] f3);
    logic [4:0] id;
    case (f3)
      3'd0: id = IdSb;
      3'd1: id = IdSh;
      3'd2: id = IdSw;
      default: id = IdUnknown;
    endcase
    return id;
  endfunction

  function automatic logic [4:0] opimm_id(input logic [2:0] f3);
    logic [4:0] id;
    case (f3)
      3'd0: id = IdAddi;
      3'd2: id = IdSlti;
      3'd3: id = IdSltiu;
      3'd4: id = IdXori;
      3'd6: id = IdOri;
      3'd7: id = IdAndi;
      default: id = IdUnknown;
    endcase
    return id;
  endfunction

endpackage

/* hdl/rv32i_subset_instruction_decoder_top.sv */
// ----------------------------------------------------------------------------
// rv32i_subset_instruction_decoder_top
// Decodes one 32-bit instruction word of a base-ISA subset per request.
//
//   Channel | Direction | Handshake               | Payload
//   in      | input     | in_valid_i / in_ready_o | in_req_i  (rv32dec_pkg::req_t)
//   out     | output    | out_valid_o/out_ready_i | out_res_o (rv32dec_pkg::res_t)
//
// A request is captured in the input register and decoded into the result
// register, which presents it on the out channel.
// One request per cycle is sustained while the output is not stalled.
// Reset clears both valid flags; payload registers are not reset.
// A stalled output holds its result; the input stage still takes one while empty.
// ----------------------------------------------------------------------------
module rv32i_subset_instruction_decoder_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rv32dec_pkg::req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rv32dec_pkg::res_t   out_res_o
);

  logic              in_valid_q;
  rv32dec_pkg::req_t in_req_q;
  logic              out_valid_q;
  rv32dec_pkg::res_t out_res_q;
  rv32dec_pkg::res_t res_d;
  logic              s2_ready;
  logic              s1_ready;

  assign s2_ready   = !out_valid_q || out_ready_i;
  assign s1_ready   = !in_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        in_valid_q <= in_valid_i;
      end
      if (s2_ready) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      in_req_q <= in_req_i;
    end
    if (s2_ready && in_valid_q) begin
      out_res_q <= res_d;
    end
  end

  always_comb begin
    logic [31:0] w;
    logic [4:0]  opc;
    logic [2:0]  f3;
    logic [31:0] imm_i;
    w     = in_req_q.instr_word;
    opc   = w[6:2];
    f3    = w[14:12];
    imm_i = {{20{w[31]}}, w[31:20]};

    res_d               = '0;
    res_d.pass_address  = in_req_q.fetch_address;
    res_d.instr_length  = 3'd4;
    res_d.format_kind   = rv32dec_pkg::FmtNone;
    res_d.instr_id      = rv32dec_pkg::IdUnknown;

    if (w[1:0] != 2'b11) begin
      res_d.instr_length  = 3'd2;
      res_d.is_compressed = 1'b1;
    end else begin
      case (opc)
        rv32dec_pkg::OpcLui: begin
          res_d.format_kind = rv32dec_pkg::FmtU;
          res_d.instr_id    = rv32dec_pkg::IdLui;
          res_d.first_reg   = w[11:7];
          res_d.immediate   = {{12{w[31]}}, w[31:12]};
        end
        rv32dec_pkg::OpcAuipc: begin
          res_d.format_kind = rv32dec_pkg::FmtU;
          res_d.instr_id    = rv32dec_pkg::IdAuipc;
          res_d.first_reg   = w[11:7];
          res_d.immediate   = {w[31:12], 12'b0};
        end
        rv32dec_pkg::OpcJal: begin
          res_d.format_kind = rv32dec_pkg::FmtJ;
          res_d.instr_id    = rv32dec_pkg::IdJal;
          res_d.is_jump     = 1'b1;
          res_d.first_reg   = w[11:7];
          res_d.immediate   = {{12{w[31]}}, w[19:12], w[20], w[30:21], 1'b0};
        end
        rv32dec_pkg::OpcJalr: begin
          res_d.format_kind = rv32dec_pkg::FmtI;
          res_d.instr_id    = (f3 == 3'd0) ? rv32dec_pkg::IdJalr : rv32dec_pkg::IdUnknown;
          res_d.is_jump     = 1'b1;
          res_d.first_reg   = w[11:7];
          res_d.second_reg  = w[19:15];
          res_d.immediate   = imm_i;
        end
        rv32dec_pkg::OpcBranch: begin
          res_d.format_kind = rv32dec_pkg::FmtB;
          res_d.instr_id    = rv32dec_pkg::branch_id(f3);
          res_d.is_jump     = 1'b1;
          res_d.first_reg   = w[19:15];
          res_d.second_reg  = w[24:20];
          res_d.immediate   = {{20{w[31]}}, w[7], w[30:25], w[11:8], 1'b0};
        end
        rv32dec_pkg::OpcLoad: begin
          res_d.format_kind = rv32dec_pkg::FmtI;
          res_d.instr_id    = rv32dec_pkg::load_id(f3);
          res_d.first_reg   = w[11:7];
          res_d.second_reg  = w[19:15];
          res_d.immediate   = imm_i;
        end
        rv32dec_pkg::OpcStore: begin
          res_d.format_kind = rv32dec_pkg::FmtS;
          res_d.instr_id    = rv32dec_pkg::store_id(f3);
          res_d.first_reg   = w[19:15];
          res_d.second_reg  = w[24:20];
          res_d.immediate   = {{20{w[31]}}, w[31:25], w[11:7]};
        end
        rv32dec_pkg::OpcOpImm: begin
          res_d.format_kind = rv32dec_pkg::FmtI;
          res_d.instr_id    = rv32dec_pkg::opimm_id(f3);
          res_d.first_reg   = w[11:7];
          res_d.second_reg  = w[19:15];
          res_d.immediate   = imm_i;
        end
        default: begin
          res_d.format_kind = rv32dec_pkg::FmtNone;
        end
      endcase

      case (res_d.format_kind)
        rv32dec_pkg::FmtI, rv32dec_pkg::FmtS, rv32dec_pkg::FmtB: begin
          res_d.operand_count = 2'd3;
        end
        rv32dec_pkg::FmtU, rv32dec_pkg::FmtJ: begin
          res_d.operand_count = 2'd2;
        end
        default: begin
          res_d.operand_count = 2'd0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;

endmodule

/* sim/rv32i_subset_instruction_decoder_top_tb.sv */
// ----------------------------------------------------------------------------
// rv32i_subset_instruction_decoder_top_tb
// Checks the instruction decoder with directed and random requests and
// compares every decoded result, field by field, with a local decode model
// while both handshake sides idle and stall at random in several phases.
// ----------------------------------------------------------------------------
module rv32i_subset_instruction_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rv32dec_pkg::*;

  localparam int unsigned PhaseLen = 150;
  localparam logic [4:0] KnownOpc [8] = '{OpcLoad, OpcOpImm, OpcAuipc, OpcStore,
                                          OpcLui, OpcBranch, OpcJalr, OpcJal};
  localparam logic [AddrWidth-1:0] AddrMax = '1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  req_t in_req_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  res_t out_res_o;

  req_t pending_reqs[$];
  res_t decoded_q[$];
  int unsigned total_reqs = 0;
  int unsigned reqs_accepted = 0;
  int unsigned fail_count = 0;
  bit req_taken = 1'b0;

  rv32i_subset_instruction_decoder_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_res_o  (out_res_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2ms;
    $display("** rv32i_subset_instruction_decoder_top: FAILED **");
    $finish;
  end

  function automatic res_t decode_rv32(input req_t req);
    res_t res;
    logic [31:0] w;
    logic [2:0] f3;
    logic [31:0] imm_i;
    w = req.instr_word;
    f3 = w[14:12];
    imm_i = {{20{w[31]}}, w[31:20]};
    res = '0;
    res.pass_address = req.fetch_address;
    if (w[1:0] != 2'b11) begin
      res.instr_length = 3'd2;
      res.is_compressed = 1'b1;
      return res;
    end
    res.instr_length = 3'd4;
    case (w[6:2])
      OpcLui: begin
        res.format_kind = FmtU;
        res.instr_id = IdLui;
        res.first_reg = w[11:7];
        res.immediate = {{12{w[31]}}, w[31:12]};
      end
      OpcAuipc: begin
        res.format_kind = FmtU;
        res.instr_id = IdAuipc;
        res.first_reg = w[11:7];
        res.immediate = {w[31:12], 12'd0};
      end
      OpcJal: begin
        res.format_kind = FmtJ;
        res.instr_id = IdJal;
        res.is_jump = 1'b1;
        res.first_reg = w[11:7];
        res.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      OpcJalr: begin
        res.format_kind = FmtI;
        res.instr_id = (f3 == 3'd0) ? IdJalr : IdUnknown;
        res.is_jump = 1'b1;
        res.first_reg = w[11:7];
        res.second_reg = w[19:15];
        res.immediate = imm_i;
      end
      OpcBranch: begin
        res.format_kind = FmtB;
        res.is_jump = 1'b1;
        res.first_reg = w[19:15];
        res.second_reg = w[24:20];
        res.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          3'd0: res.instr_id = IdBeq;
          3'd1: res.instr_id = IdBne;
          3'd4: res.instr_id = IdBlt;
          3'd5: res.instr_id = IdBge;
          3'd6: res.instr_id = IdBltu;
          3'd7: res.instr_id = IdBgeu;
          default: res.instr_id = IdUnknown;
        endcase
      end
      OpcLoad: begin
        res.format_kind = FmtI;
        res.first_reg = w[11:7];
        res.second_reg = w[19:15];
        res.immediate = imm_i;
        case (f3)
          3'd0: res.instr_id = IdLb;
          3'd1: res.instr_id = IdLh;
          3'd2: res.instr_id = IdLw;
          3'd4: res.instr_id = IdLbu;
          3'd5: res.instr_id = IdLhu;
          default: res.instr_id = IdUnknown;
        endcase
      end
      OpcStore: begin
        res.format_kind = FmtS;
        res.first_reg = w[19:15];
        res.second_reg = w[24:20];
        res.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          3'd0: res.instr_id = IdSb;
          3'd1: res.instr_id = IdSh;
          3'd2: res.instr_id = IdSw;
          default: res.instr_id = IdUnknown;
        endcase
      end
      OpcOpImm: begin
        res.format_kind = FmtI;
        res.first_reg = w[11:7];
        res.second_reg = w[19:15];
        res.immediate = imm_i;
        case (f3)
          3'd0: res.instr_id = IdAddi;
          3'd2: res.instr_id = IdSlti;
          3'd3: res.instr_id = IdSltiu;
          3'd4: res.instr_id = IdXori;
          3'd6: res.instr_id = IdOri;
          3'd7: res.instr_id = IdAndi;
          default: res.instr_id = IdUnknown;
        endcase
      end
      default: ;
    endcase
    if (res.format_kind == FmtI || res.format_kind == FmtS || res.format_kind == FmtB) begin
      res.operand_count = 2'd3;
    end else if (res.format_kind == FmtU || res.format_kind == FmtJ) begin
      res.operand_count = 2'd2;
    end
    return res;
  endfunction

  function automatic logic [31:0] with_opcode(input logic [31:0] body, input logic [4:0] opc);
    return {body[31:7], opc, 2'b11};
  endfunction

  function automatic logic [31:0] with_funct3(input logic [31:0] w, input logic [2:0] f3);
    return {w[31:15], f3, w[11:0]};
  endfunction

  task automatic push_req(input logic [31:0] word, input logic [AddrWidth-1:0] addr);
    req_t req;
    req.instr_word = word;
    req.fetch_address = addr;
    pending_reqs.push_back(req);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk_i) begin : monitor_proc
    res_t want;
    req_taken = rst_ni && in_valid_i && in_ready_o;
    if (req_taken) begin
      decoded_q.push_back(decode_rv32(in_req_i));
      reqs_accepted++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = decoded_q.pop_front();
        check_field("pass_address", 64'(want.pass_address), 64'(out_res_o.pass_address));
        check_field("instr_length", 64'(want.instr_length), 64'(out_res_o.instr_length));
        check_field("is_compressed", 64'(want.is_compressed), 64'(out_res_o.is_compressed));
        check_field("is_jump", 64'(want.is_jump), 64'(out_res_o.is_jump));
        check_field("format_kind", 64'(want.format_kind), 64'(out_res_o.format_kind));
        check_field("operand_count", 64'(want.operand_count), 64'(out_res_o.operand_count));
        check_field("first_reg", 64'(want.first_reg), 64'(out_res_o.first_reg));
        check_field("second_reg", 64'(want.second_reg), 64'(out_res_o.second_reg));
        check_field("immediate", 64'(want.immediate), 64'(out_res_o.immediate));
        check_field("instr_id", 64'(want.instr_id), 64'(out_res_o.instr_id));
      end
    end
  end

  always @(negedge clk_i) begin : driver_proc
    int unsigned send_idle_pct;
    int unsigned stall_pct;
    if (rst_ni) begin
      case ((reqs_accepted / PhaseLen) % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      if (!in_valid_i || req_taken) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_req_i <= pending_reqs.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin : stimulus_proc
    logic [31:0] word;
    logic [AddrWidth-1:0] addr;
    int unsigned pick;

    // Compressed words with each non-11 low pair, and the address extremes.
    push_req(32'h0000_0000, '0);
    push_req(32'hffff_fffd, AddrMax);
    push_req(32'hffff_fffe, 63'h2aaa_aaaa_aaaa_aaaa);
    push_req(with_opcode('1, OpcLui), AddrMax);
    push_req(with_opcode('0, OpcLui), '0);
    push_req(with_opcode('1, OpcAuipc), 63'h5555_5555_5555_5555);
    push_req(with_opcode(32'h8000_0000, OpcAuipc), '0);
    push_req(with_opcode('1, OpcJal), AddrMax);
    push_req(with_opcode(32'h8000_0000, OpcJal), '0);
    push_req(with_opcode(32'h7fff_ffff, OpcJal), 63'd4);
    push_req(with_funct3(with_opcode('1, OpcJalr), 3'd0), AddrMax);
    push_req(with_funct3(with_opcode('0, OpcJalr), 3'd1), '0);
    push_req(with_funct3(with_opcode('1, OpcBranch), 3'd0), 63'd8);
    push_req(with_funct3(with_opcode(32'h7fff_ffff, OpcBranch), 3'd7), 63'd12);
    push_req(with_funct3(with_opcode('0, OpcBranch), 3'd2), '0);
    push_req(with_funct3(with_opcode('1, OpcLoad), 3'd2), AddrMax);
    push_req(with_funct3(with_opcode('0, OpcLoad), 3'd3), '0);
    push_req(with_funct3(with_opcode('1, OpcStore), 3'd2), AddrMax);
    push_req(with_funct3(with_opcode(32'h7fff_ffff, OpcStore), 3'd7), '0);
    push_req(with_funct3(with_opcode('1, OpcOpImm), 3'd7), 63'd16);
    push_req(with_funct3(with_opcode(32'h4000_0000, OpcOpImm), 3'd1), 63'd20);
    push_req(with_funct3(with_opcode(32'h4000_0000, OpcOpImm), 3'd5), 63'd24);
    push_req(with_opcode('1, 5'h0c), AddrMax);
    push_req(with_opcode('0, 5'h1c), '0);
    push_req(32'hffff_ffff, AddrMax);

    repeat (1100) begin
      word = $urandom;
      pick = $urandom_range(99);
      if (pick < 8) begin
        word[1:0] = 2'($urandom_range(2));
      end else if (pick < 20) begin
        word[1:0] = 2'b11;
      end else begin
        word = with_opcode(word, KnownOpc[3'($urandom_range(7))]);
      end
      pick = $urandom_range(19);
      if (pick == 0) begin
        addr = '0;
      end else if (pick == 1) begin
        addr = AddrMax;
      end else begin
        addr = AddrWidth'({$urandom, $urandom});
      end
      push_req(word, addr);
    end
    total_reqs = pending_reqs.size();

    while (reqs_accepted < total_reqs || decoded_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("** rv32i_subset_instruction_decoder_top: PASSED **");
    end else begin
      $display("** rv32i_subset_instruction_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
